FILE: hdl/psd_pkg.sv
`default_nettype none
package psd_pkg;
	localparam int CoordW = 24;
	localparam int DiffW  = 25;
	localparam int DistW  = 25;
	// root digits: result below 2^25
	localparam int Steps  = 26;
	// squared length below 2^49
	localparam int LenW   = 50;
	// d*len2 below 2^75
	localparam int TW     = 76;
	// cross^2 below 2^98, trial step below 2^101
	localparam int RemW   = 102;

	typedef struct packed {
		logic [RemW-1:0] rem;
		logic [TW-1:0]   t;
		logic [LenW-1:0] m;
		logic [DistW:0]  root;
		logic            degen;
	} psd_cell_t;
endpackage
`default_nettype wire

FILE: hdl/psd_sqrt_cell.sv
`default_nettype none
// One root digit: largest d with d*d*m <= radicand; one pipeline stage.
module psd_sqrt_cell #(
	parameter int Idx = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              vin,
	input  wire psd_pkg::psd_cell_t din,
	output logic                   vout,
	output psd_pkg::psd_cell_t     dout
);
	import psd_pkg::*;

	logic [RemW-1:0] delta;
	logic            take;
	psd_cell_t       nxt;

	// (d + 2^k)^2*m - d^2*m = (d*m << k+1) + (m << 2k); t carries d*m
	always_comb begin
		delta = (RemW'(din.t) << (Idx+1)) + (RemW'(din.m) << (2*Idx));
		take  = din.rem >= delta;
		nxt       = din;
		nxt.rem   = take ? din.rem - delta : din.rem;
		nxt.t     = take ? din.t + (TW'(din.m) << Idx) : din.t;
		nxt.root[Idx] = take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vout <= 1'b0;
		else if (adv) vout <= vin;
	end

	always_ff @(posedge clk) begin
		if (adv) dout <= nxt;
	end
endmodule
`default_nettype wire

FILE: hdl/point_segment_distance.sv
`default_nettype none
// channel | valid    | stall    | payload
// in      | in_valid | in_stall | point_*, seg_start_*, seg_end_*
// out     | out_valid| out_stall| distance, degenerate
// One item per cycle while out_stall does not hold the output. 5 front stages feed 26 root cells.
// The pipeline advances whenever its last stage is empty or taken.
// Reset clears the valid bits only.
module point_segment_distance (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [23:0] point_x,
	input  wire logic [23:0] point_y,
	input  wire logic [23:0] seg_start_x,
	input  wire logic [23:0] seg_start_y,
	input  wire logic [23:0] seg_end_x,
	input  wire logic [23:0] seg_end_y,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [24:0]      distance,
	output logic             degenerate
);
	import psd_pkg::*;

	logic adv;
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// s1: differences
	logic v1, v2, v3, v4, v5;
	logic signed [DiffW-1:0] pax_s1, pay_s1, bax_s1, bay_s1, pbx_s1, pby_s1;
	always_ff @(posedge clk) if (adv) begin
		pax_s1 <= DiffW'($signed(point_x)) - DiffW'($signed(seg_start_x));
		pay_s1 <= DiffW'($signed(point_y)) - DiffW'($signed(seg_start_y));
		bax_s1 <= DiffW'($signed(seg_end_x)) - DiffW'($signed(seg_start_x));
		bay_s1 <= DiffW'($signed(seg_end_y)) - DiffW'($signed(seg_start_y));
		pbx_s1 <= DiffW'($signed(point_x)) - DiffW'($signed(seg_end_x));
		pby_s1 <= DiffW'($signed(point_y)) - DiffW'($signed(seg_end_y));
	end

	// s2: products
	logic signed [49:0] p1_s2, p2_s2, p3_s2, p4_s2, p5_s2, p6_s2, p7_s2, p8_s2;
	logic signed [49:0] p9_s2, p10_s2;
	always_ff @(posedge clk) if (adv) begin
		p1_s2 <= bax_s1 * bax_s1;  p2_s2 <= bay_s1 * bay_s1;
		p3_s2 <= pax_s1 * bax_s1;  p4_s2 <= pay_s1 * bay_s1;
		p5_s2 <= pax_s1 * bay_s1;  p6_s2 <= pay_s1 * bax_s1;
		p7_s2 <= pax_s1 * pax_s1;  p8_s2 <= pay_s1 * pay_s1;
		p9_s2 <= pbx_s1 * pbx_s1;  p10_s2 <= pby_s1 * pby_s1;
	end

	// s3: sums and |cross|
	logic [51:0] len2_s3, hpa_s3, hpb_s3, crm_s3;
	logic signed [51:0] dot_s3;
	always_ff @(posedge clk) if (adv) begin
		len2_s3 <= 52'(p1_s2) + 52'(p2_s2);
		dot_s3  <= 52'(p3_s2) + 52'(p4_s2);
		hpa_s3  <= 52'(p7_s2) + 52'(p8_s2);
		hpb_s3  <= 52'(p9_s2) + 52'(p10_s2);
		crm_s3  <= (p5_s2 >= p6_s2) ? 52'(p5_s2 - p6_s2) : 52'(p6_s2 - p5_s2);
	end

	// s4: pick the case; square |cross| (below 2^49) as three partial products
	logic            int_s4, dg_s4;
	logic [LenW-1:0] len2_s4;
	logic [51:0]     hp_s4;
	logic [49:0]     ll_s4;
	logic [48:0]     lh_s4;
	logic [47:0]     hh_s4;
	always_ff @(posedge clk) if (adv) begin
		dg_s4   <= len2_s3 == '0;
		len2_s4 <= len2_s3[LenW-1:0];
		ll_s4   <= crm_s3[24:0] * crm_s3[24:0];
		lh_s4   <= crm_s3[48:25] * crm_s3[24:0];
		hh_s4   <= crm_s3[48:25] * crm_s3[48:25];
		if (len2_s3 == '0 || dot_s3 <= 0) begin
			int_s4 <= 1'b0; hp_s4 <= hpa_s3;
		end else if (dot_s3 >= $signed(len2_s3)) begin
			int_s4 <= 1'b0; hp_s4 <= hpb_s3;
		end else begin
			int_s4 <= 1'b1; hp_s4 <= hpa_s3;
		end
	end

	// s5: root chain operands; interior solves d*d*len2 <= cross^2,
	// end cases solve d*d <= squared distance
	logic [RemW-1:0] rad_s5;
	logic [LenW-1:0] m_s5;
	logic            dg_s5;
	always_ff @(posedge clk) if (adv) begin
		dg_s5 <= dg_s4;
		if (int_s4) begin
			rad_s5 <= (RemW'(hh_s4) << 50) + (RemW'(lh_s4) << 26) + RemW'(ll_s4);
			m_s5   <= len2_s4;
		end else begin
			rad_s5 <= RemW'(hp_s4);
			m_s5   <= LenW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) {v1, v2, v3, v4, v5} <= '0;
		else if (adv) {v1, v2, v3, v4, v5} <= {in_valid, v1, v2, v3, v4};
	end

	// root chain
	psd_cell_t cd [Steps+1];
	logic      cv [Steps+1];
	assign cv[0] = v5;
	assign cd[0] = '{rem: rad_s5, t: '0, m: m_s5, root: '0, degen: dg_s5};

	for (genvar g = 0; g < Steps; g++) begin : g_cell
		psd_sqrt_cell #(.Idx(Steps-1-g)) u_cell (
			.clk(clk), .arst_n(arst_n), .adv(adv),
			.vin(cv[g]), .din(cd[g]), .vout(cv[g+1]), .dout(cd[g+1])
		);
	end

	assign out_valid  = cv[Steps];
	assign distance   = cd[Steps].root[DistW-1:0];
	assign degenerate = cd[Steps].degen;
endmodule
`default_nettype wire

FILE: test/point_segment_distance_test.sv
`default_nettype none
module point_segment_distance_test;
	import psd_pkg::*;

	// Expected result of one distance query
	typedef struct {
		logic [DistW-1:0] dist_val;
		logic             degen;
	} dist_result_t;

	// Directed stimulus row; check_dist set when the result is typed in
	typedef struct {
		logic [CoordW-1:0] px, py, ax, ay, bx, by;
		bit                check_dist;
		logic [DistW-1:0]  exp_dist;
		logic              degen;
	} query_row_t;

	localparam logic [CoordW-1:0] CMax = 24'h7fffff;
	localparam logic [CoordW-1:0] CMin = 24'h800000;
	localparam logic [CoordW-1:0] One  = 24'h010000;
	localparam logic [CoordW-1:0] NOne = 24'hff0000;
	localparam int RandItems = 950;
	localparam int DrainCycles = 80;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall, degenerate;
	logic [CoordW-1:0] point_x, point_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y;
	logic [DistW-1:0] distance;

	dist_result_t expected_q[$];
	int mismatches, results_seen, degen_seen;

	point_segment_distance dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.point_x(point_x), .point_y(point_y),
		.seg_start_x(seg_start_x), .seg_start_y(seg_start_y),
		.seg_end_x(seg_end_x), .seg_end_y(seg_end_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.distance(distance), .degenerate(degenerate)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Floor square root, bit by bit
	function automatic longint unsigned floor_sqrt(longint unsigned x);
		longint unsigned r;
		r = 0;
		for (int k = 31; k >= 0; k--) begin
			longint unsigned c;
			c = r | (64'd1 << k);
			if (c * c <= x)
				r = c;
		end
		return r;
	endfunction

	// Distance from point to clamped projection on the segment
	function automatic dist_result_t seg_distance(logic [CoordW-1:0] px, py, ax, ay, bx, by);
		dist_result_t res;
		longint sx_p, sy_p, sx_a, sy_a, sx_b, sy_b, pax, pay, bax, bay, len2, dot_pb, cr;
		logic [127:0] cr2, trial;
		logic [DistW:0] d, cand;
		sx_p = longint'(signed'(px)); sy_p = longint'(signed'(py));
		sx_a = longint'(signed'(ax)); sy_a = longint'(signed'(ay));
		sx_b = longint'(signed'(bx)); sy_b = longint'(signed'(by));
		pax = sx_p - sx_a; pay = sy_p - sy_a;
		bax = sx_b - sx_a; bay = sy_b - sy_a;
		len2 = bax * bax + bay * bay;
		dot_pb = pax * bax + pay * bay;
		res.degen = (len2 == 0);
		if (len2 == 0 || dot_pb <= 0)
			res.dist_val = DistW'(floor_sqrt(pax * pax + pay * pay));
		else if (dot_pb >= len2)
			res.dist_val = DistW'(floor_sqrt((sx_p - sx_b) * (sx_p - sx_b)
				+ (sy_p - sy_b) * (sy_p - sy_b)));
		else begin
			cr = pax * bay - pay * bax;
			if (cr < 0)
				cr = -cr;
			cr2 = 128'(cr) * 128'(cr);
			d = '0;
			for (int k = 25; k >= 0; k--) begin
				cand = d | (26'd1 << k);
				trial = 128'(cand) * 128'(cand) * 128'(len2);
				if (trial <= cr2)
					d = cand;
			end
			res.dist_val = d[DistW-1:0];
		end
		return res;
	endfunction

	// Send one query, holding it while stalled; sampled at the rising edge
	task automatic send_query(logic [CoordW-1:0] px, py, ax, ay, bx, by);
		point_x <= px; point_y <= py;
		seg_start_x <= ax; seg_start_y <= ay;
		seg_end_x <= bx; seg_end_y <= by;
		in_valid <= 1'b1;
		expected_q.push_back(seg_distance(px, py, ax, ay, bx, by));
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Random gap at the sender, between bursts
	int burst_left;
	task automatic sender_gap();
		if (burst_left == 0) begin
			int gap;
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
	endtask

	function automatic logic [CoordW-1:0] rand_coord(int mode);
		case (mode)
			0: return CoordW'($urandom());
			1: return CoordW'($signed($urandom_range(0, 1023)) - 512);
			2: return ($urandom_range(0, 1)) ? CMax : CMin;
			default: return CoordW'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
		endcase
	endfunction

	// Receiver stall pattern: random-length stretches, each free or with its own stall density
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			int mode, len;
			mode = $urandom_range(0, 3);
			len = $urandom_range(1, 40);
			repeat (len) begin
				@(negedge clk);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 1) == 0);
					default: out_stall <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: distance=%0d degenerate=%0b", distance, degenerate);
			end else begin
				dist_result_t e;
				e = expected_q.pop_front();
				results_seen++;
				if (e.degen)
					degen_seen++;
				if (distance !== e.dist_val || degenerate !== e.degen) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: distance exp %0d got %0d, degenerate exp %0b got %0b",
							e.dist_val, distance, e.degen, degenerate);
				end
			end
		end
	end

	// Watchdog
	initial begin
		#2000000;
		$display("timeout with %0d results still pending", expected_q.size());
		$display("simulation failed");
		$finish;
	end

	// Stimulus
	initial begin
		query_row_t dir_rows[$];
		in_valid = 1'b0;
		point_x = '0; point_y = '0;
		seg_start_x = '0; seg_start_y = '0;
		seg_end_x = '0; seg_end_y = '0;
		mismatches = 0; results_seen = 0; degen_seen = 0; burst_left = 0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// all zero, degenerate at origin
		dir_rows.push_back('{0, 0, 0, 0, 0, 0, 1, 0, 1});
		// degenerate, point one unit away
		dir_rows.push_back('{One, 0, 0, 0, 0, 0, 1, 25'h10000, 1});
		// before start: distance to start
		dir_rows.push_back('{NOne, 0, 0, 0, One, 0, 1, 25'h10000, 0});
		// past end: distance to end
		dir_rows.push_back('{24'h020000, 0, 0, 0, One, 0, 1, 25'h10000, 0});
		// interior, perpendicular distance
		dir_rows.push_back('{24'h008000, One, 0, 0, One, 0, 1, 25'h10000, 0});
		// point on segment interior
		dir_rows.push_back('{24'h008000, 0, 0, 0, One, 0, 1, 0, 0});
		// projection exactly at end
		dir_rows.push_back('{One, One, 0, 0, One, 0, 1, 25'h10000, 0});
		// opposite corners, degenerate at min and at max
		dir_rows.push_back('{CMax, CMax, CMin, CMin, CMin, CMin, 1, 25'd23726564, 1});
		dir_rows.push_back('{CMin, CMin, CMax, CMax, CMax, CMax, 1, 25'd23726564, 1});
		// remaining extremes and mixed values checked by predictor
		dir_rows.push_back('{CMax, CMin, CMin, CMax, CMax, CMax, 0, 0, 0});
		dir_rows.push_back('{0, CMax, CMin, 0, CMax, 0, 0, 0, 0});
		dir_rows.push_back('{CMin, 0, CMin, CMin, CMax, CMax, 0, 0, 0});
		dir_rows.push_back('{CMax, CMax, CMin, CMax, CMax, CMin, 0, 0, 0});
		dir_rows.push_back('{24'h000001, 24'h000001, 0, 0, 24'h000002, 24'h000001, 0, 0, 0});
		dir_rows.push_back('{24'h123456, 24'hfedcba, 24'h800001, 24'h7ffffe, 24'h000003, 24'hfffffd, 0, 0, 0});
		dir_rows.push_back('{24'h555555, 24'haaaaaa, 24'haaaaaa, 24'h555555, 24'hffffff, 24'hffffff, 0, 0, 0});

		foreach (dir_rows[i]) begin
			query_row_t r;
			dist_result_t p;
			r = dir_rows[i];
			p = seg_distance(r.px, r.py, r.ax, r.ay, r.bx, r.by);
			if (r.check_dist && (p.dist_val !== r.exp_dist || p.degen !== r.degen)) begin
				mismatches++;
				if (mismatches <= 10)
					$display("row %0d: typed result %0d/%0b, predicted %0d/%0b",
						i, r.exp_dist, r.degen, p.dist_val, p.degen);
			end
			sender_gap();
			send_query(r.px, r.py, r.ax, r.ay, r.bx, r.by);
		end

		// Random queries, mixed coordinate ranges
		for (int n = 0; n < RandItems; n++) begin
			logic [CoordW-1:0] c[6];
			int mode;
			mode = $urandom_range(0, 4);
			foreach (c[j])
				c[j] = rand_coord(mode == 4 ? $urandom_range(0, 3) : mode);
			// sometimes collapse the segment, or put the point on an end
			case ($urandom_range(0, 9))
				0: begin c[4] = c[2]; c[5] = c[3]; end
				1: begin c[0] = c[2]; c[1] = c[3]; end
				2: begin c[0] = c[4]; c[1] = c[5]; end
				default: ;
			endcase
			sender_gap();
			send_query(c[0], c[1], c[2], c[3], c[4], c[5]);
		end
		in_valid <= 1'b0;

		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);

		$display("%0d queries checked, %0d with a zero-length segment; %0d mismatches",
			results_seen, degen_seen, mismatches);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire
